>>> sv/shortest_edit_script_engine_macros.svh
// Assertion macros used by the checker of the shortest edit script engine
`ifndef SHORTEST_EDIT_SCRIPT_ENGINE_MACROS_SVH
`define SHORTEST_EDIT_SCRIPT_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SES_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ses_pkg.sv
// Package: sizes, codes and controller/datapath interface types of the edit script engine
package ses_pkg;

    localparam int MAX_LEN    = 32;
    localparam int TOKEN_BITS = 32;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int SA_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIAGS      = 2 * MAX_LEN + 1;
    localparam int D_W        = $clog2(DIAGS);
    localparam int K_W        = D_W + 1;
    localparam int TR_DEPTH   = DIAGS * DIAGS;
    localparam int TA_W       = $clog2(TR_DEPTH);
    localparam int CA_W       = TA_W + 2;

    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [1:0] OP_COMMON = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DEL    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic load;
        logic start;
        logic next_k;
        logic y_zero;
        logic rd_lo;
        logic rd_hi;
        logic set_y;
        logic snk_rd;
        logic snk_inc;
        logic tr_wr;
        logic found;
        logic y0_rd;
        logic y0_set;
        logic rd_y;
        logic set_ycur;
        logic set_cnt;
        logic emit_common;
        logic emit_op;
        logic emit_none;
        logic clear;
    } ses_cmd_t;

    typedef struct packed {
        logic k_out;
        logic d_zero;
        logic snk_go;
        logic tok_eq;
        logic at_end;
        logic cnt_zero;
        logic out_free;
        logic none_needed;
    } ses_sts_t;

endpackage

>>> sv/shortest_edit_script_engine.sv
// Load items (A or B element) are taken one per cycle. A compute item holds s_tready low
// while the search and the script output run: each diagonal in range reads its reach from
// the reach trace RAM and extends over each matching token pair, a diagonal out of range is
// skipped, and after setup the walk back reads the trace for each add or delete and emits
// the common ops, all paced by the single read port of the reach trace RAM and the token RAMs;
// the output also stalls while m_tready is low. Results leave from the end of the script back
// to its start, each carrying the distance; the last carries tlast. Both lengths clear after.
module shortest_edit_script_engine import ses_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element_value
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // distance[6:0], zero pad
    output logic [1:0]  m_tuser,   // edit_op
    output logic        m_tlast    // last_op
);

    ses_cmd_t cmd;
    ses_sts_t sts;

    ses_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ses_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sv/ses_ram.sv
// Generic single-write, single-read RAM with registered read data
module ses_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ses_ctrl.sv
// Controller: sequences loading, diagonal search, trace walk-back and result emission
module ses_ctrl import ses_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  ses_sts_t   sts,
    output ses_cmd_t   cmd
);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_DIAG      = 14'h0002,
        ST_RD_HI     = 14'h0004,
        ST_RD_DEC    = 14'h0008,
        ST_SNK_ISSUE = 14'h0010,
        ST_SNK_CMP   = 14'h0020,
        ST_DIAG_END  = 14'h0040,
        ST_BT_Y0     = 14'h0080,
        ST_BT_Y0W    = 14'h0100,
        ST_BT_RDY    = 14'h0200,
        ST_BT_YCUR   = 14'h0400,
        ST_BT_RDHI   = 14'h0800,
        ST_BT_DEC    = 14'h1000,
        ST_EMIT      = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser inside {REQ_LOAD_A, REQ_LOAD_B}) begin
                        cmd.load = 1'b1;
                    end else if (s_tuser == REQ_COMPUTE) begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIAG;
                    end
                end
            end
            ST_DIAG: begin
                if (sts.k_out) begin
                    cmd.next_k = 1'b1;
                end else if (sts.d_zero) begin
                    cmd.y_zero = 1'b1;
                    state_next = ST_SNK_ISSUE;
                end else begin
                    cmd.rd_lo  = 1'b1;
                    state_next = ST_RD_HI;
                end
            end
            ST_RD_HI: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_RD_DEC;
            end
            ST_RD_DEC: begin
                cmd.set_y  = 1'b1;
                state_next = ST_SNK_ISSUE;
            end
            ST_SNK_ISSUE: begin
                if (sts.snk_go) begin
                    cmd.snk_rd = 1'b1;
                    state_next = ST_SNK_CMP;
                end else begin
                    state_next = ST_DIAG_END;
                end
            end
            ST_SNK_CMP: begin
                if (sts.tok_eq) begin
                    cmd.snk_inc = 1'b1;
                    state_next  = ST_SNK_ISSUE;
                end else begin
                    state_next = ST_DIAG_END;
                end
            end
            ST_DIAG_END: begin
                cmd.tr_wr = 1'b1;
                if (sts.at_end) begin
                    cmd.found  = 1'b1;
                    state_next = ST_BT_Y0;
                end else begin
                    cmd.next_k = 1'b1;
                    state_next = ST_DIAG;
                end
            end
            ST_BT_Y0: begin
                cmd.y0_rd  = 1'b1;
                state_next = ST_BT_Y0W;
            end
            ST_BT_Y0W: begin
                cmd.y0_set = 1'b1;
                state_next = ST_BT_RDY;
            end
            ST_BT_RDY: begin
                cmd.rd_y   = 1'b1;
                state_next = ST_BT_YCUR;
            end
            ST_BT_YCUR: begin
                cmd.set_ycur = 1'b1;
                if (sts.d_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.rd_lo  = 1'b1;
                    state_next = ST_BT_RDHI;
                end
            end
            ST_BT_RDHI: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_BT_DEC;
            end
            ST_BT_DEC: begin
                cmd.set_cnt = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    if (!sts.cnt_zero) begin
                        cmd.emit_common = 1'b1;
                    end else if (!sts.d_zero) begin
                        cmd.emit_op = 1'b1;
                        state_next  = ST_BT_RDY;
                    end else begin
                        // end of the walk back: a single "none" item only when both sequences are empty
                        cmd.emit_none = sts.none_needed;
                        cmd.clear     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/ses_dp.sv
// Datapath: sequence stores, reach trace, diagonal arithmetic and output register
module ses_dp import ses_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  ses_cmd_t    cmd,
    output ses_sts_t    sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam logic signed [CA_W-1:0] ML_C  = CA_W'(MAX_LEN);
    localparam logic signed [CA_W-1:0] DG_C  = CA_W'(DIAGS);
    localparam logic signed [CA_W-1:0] ONE_C = CA_W'(1);
    localparam logic signed [K_W:0]    TWO_K = (K_W+1)'(2);

    logic [LEN_W-1:0]      len_a_reg, len_b_reg;
    logic [D_W-1:0]        d_reg, fd_reg;
    logic signed [K_W-1:0] k_reg;
    logic [TA_W-1:0]       base_reg;
    logic [LEN_W-1:0]      y_reg, lo_reg, y0_reg, ycur_reg, cnt_reg;
    logic                  del_reg;
    logic                  valid_reg, last_reg;
    logic [1:0]            op_reg;
    logic [6:0]            dist_reg;

    logic                  a_we, b_we;
    logic [TOKEN_BITS-1:0] a_rdata, b_rdata, tok;
    logic [TA_W-1:0]       tr_raddr;
    logic [LEN_W-1:0]      tr_rdata;

    logic signed [CA_W-1:0] base_c, cur_addr, lo_addr, hi_addr;
    logic signed [K_W:0]    k1, d1, na_x, nb_x, x_s;
    logic [LEN_W:0]         lo_p1;
    logic                   pick_del;
    logic [LEN_W-1:0]       ystart;

    assign tok  = s_tdata[TOKEN_BITS-1:0];
    assign a_we = cmd.load && (s_tuser == REQ_LOAD_A) && (len_a_reg < LEN_W'(MAX_LEN));
    assign b_we = cmd.load && (s_tuser == REQ_LOAD_B) && (len_b_reg < LEN_W'(MAX_LEN));

    // trace is laid out as row d at base d*DIAGS, diagonal k at column k+MAX_LEN
    assign base_c   = $signed(CA_W'(base_reg));
    assign cur_addr = base_c + CA_W'(k_reg) + ML_C;
    assign lo_addr  = cur_addr - DG_C - ONE_C;
    assign hi_addr  = cur_addr - DG_C + ONE_C;

    always_comb begin
        if (cmd.rd_lo) begin
            tr_raddr = lo_addr[TA_W-1:0];
        end else if (cmd.rd_hi) begin
            tr_raddr = hi_addr[TA_W-1:0];
        end else if (cmd.y0_rd) begin
            tr_raddr = ML_C[TA_W-1:0];
        end else begin
            tr_raddr = cur_addr[TA_W-1:0];
        end
    end

    assign k1   = (K_W+1)'(k_reg);
    assign d1   = $signed((K_W+1)'(d_reg));
    assign na_x = $signed((K_W+1)'(len_a_reg));
    assign nb_x = $signed((K_W+1)'(len_b_reg));
    assign x_s  = $signed((K_W+1)'(y_reg)) - k1;

    // step rule: delete at the lower edges, add at the upper edges, else compare reaches
    assign lo_p1    = {1'b0, lo_reg} + (LEN_W+1)'(1);
    assign pick_del = (k1 == -d1 || k1 == -na_x) ? 1'b1 :
                      (k1 == d1 || k1 == nb_x)   ? 1'b0 :
                      (lo_p1 < {1'b0, tr_rdata});
    assign ystart   = pick_del ? tr_rdata : lo_p1[LEN_W-1:0];

    assign sts.k_out       = (k1 < -na_x) || (k1 > nb_x);
    assign sts.d_zero      = (d_reg == '0);
    assign sts.snk_go      = (x_s >= 0) && (x_s < na_x) && (y_reg < len_b_reg);
    assign sts.tok_eq      = (a_rdata == b_rdata);
    assign sts.at_end      = (x_s >= na_x) && (y_reg >= len_b_reg);
    assign sts.cnt_zero    = (cnt_reg == '0);
    assign sts.out_free    = !valid_reg || m_tready;
    assign sts.none_needed = (fd_reg == '0) && (y0_reg == '0);

    ses_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_LEN)) u_seq_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (len_a_reg[SA_W-1:0]),
        .wdata (tok),
        .raddr (x_s[SA_W-1:0]),
        .rdata (a_rdata)
    );

    ses_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_LEN)) u_seq_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (len_b_reg[SA_W-1:0]),
        .wdata (tok),
        .raddr (y_reg[SA_W-1:0]),
        .rdata (b_rdata)
    );

    ses_ram #(.WIDTH(LEN_W), .DEPTH(TR_DEPTH)) u_trace (
        .aclk  (aclk),
        .we    (cmd.tr_wr),
        .waddr (cur_addr[TA_W-1:0]),
        .wdata (y_reg),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (a_we) begin
                len_a_reg <= len_a_reg + LEN_W'(1);
            end
            if (b_we) begin
                len_b_reg <= len_b_reg + LEN_W'(1);
            end
            if (cmd.clear) begin
                len_a_reg <= '0;
                len_b_reg <= '0;
            end
            if (cmd.emit_common || cmd.emit_op || cmd.emit_none) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            d_reg    <= '0;
            k_reg    <= '0;
            base_reg <= '0;
        end else if (cmd.next_k) begin
            if (k1 + TWO_K > d1) begin
                d_reg    <= d_reg + D_W'(1);
                k_reg    <= -K_W'(d_reg) - K_W'(1);
                base_reg <= base_reg + TA_W'(DIAGS);
            end else begin
                k_reg <= k_reg + K_W'(2);
            end
        end else if (cmd.emit_op) begin
            k_reg    <= del_reg ? k_reg + K_W'(1) : k_reg - K_W'(1);
            d_reg    <= d_reg - D_W'(1);
            base_reg <= base_reg - TA_W'(DIAGS);
        end

        if (cmd.y_zero) begin
            y_reg <= '0;
        end else if (cmd.set_y) begin
            y_reg <= ystart;
        end else if (cmd.snk_inc) begin
            y_reg <= y_reg + LEN_W'(1);
        end

        if (cmd.rd_hi) begin
            lo_reg <= tr_rdata;
        end
        if (cmd.found) begin
            fd_reg <= d_reg;
        end
        if (cmd.y0_set) begin
            y0_reg <= tr_rdata;
        end
        if (cmd.set_ycur) begin
            ycur_reg <= tr_rdata;
            cnt_reg  <= tr_rdata;
        end else if (cmd.set_cnt) begin
            cnt_reg <= ycur_reg - ystart;
            del_reg <= pick_del;
        end else if (cmd.emit_common) begin
            cnt_reg <= cnt_reg - LEN_W'(1);
        end

        if (cmd.emit_common) begin
            op_reg   <= OP_COMMON;
            last_reg <= sts.d_zero && (cnt_reg == LEN_W'(1));
            dist_reg <= 7'(fd_reg);
        end else if (cmd.emit_op) begin
            op_reg   <= del_reg ? OP_DEL : OP_ADD;
            last_reg <= (d_reg == D_W'(1)) && (y0_reg == '0);
            dist_reg <= 7'(fd_reg);
        end else if (cmd.emit_none) begin
            op_reg   <= OP_NONE;
            last_reg <= 1'b1;
            dist_reg <= '0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, dist_reg};
    assign m_tuser  = op_reg;
    assign m_tlast  = last_reg;

endmodule

>>> sv/ses_checker.sv
// Port-level checker for the edit script engine, bound to the top level
`include "shortest_edit_script_engine_macros.svh"

module ses_checker import ses_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `SES_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `SES_ASSERT_NOW(a_none_form, aclk, aresetn, m_tvalid && m_tuser == OP_NONE, m_tlast && m_tdata == 8'd0, "none item must be last with zero distance")
    `SES_ASSERT_NOW(a_edit_dist, aclk, aresetn, m_tvalid && (m_tuser == OP_ADD || m_tuser == OP_DEL), m_tdata != 8'd0, "edit op with zero distance")
    `SES_ASSERT_NOW(a_busy_in, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input taken mid-script")

endmodule

bind shortest_edit_script_engine ses_checker u_ses_checker (.*);
